>>> rtl/c3cf_pkg.sv
// shared types and constants of the 3x3 clamp filter
package c3cf_pkg;

   localparam int MAX_SIZE_DEF       = 2048;
   localparam int COEF_FRAC_BITS_DEF = 10;

   localparam int PIX_W            = 8;
   localparam int PIX_MAX          = 255;
   localparam int TAPS             = 3;
   localparam int FRAME_SIZE_W     = 12;
   localparam int FRAME_SIZE_RESET = 1024;
   localparam int FRAME_SIZE_MIN   = 3;
   localparam int CSR_DATA_W       = 36;

   // cycles from an accepted req beat to its rsp beat with no stall
   localparam int RSP_LATENCY = 4;

   localparam logic KIND_PIXEL = 1'b0;

   typedef enum logic [1:0] {
      CSR_FRAME_SIZE = 2'd0,
      CSR_COEF_TOP   = 2'd1,
      CSR_COEF_MID   = 2'd2,
      CSR_COEF_BOT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] pixel;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_pixel;
      logic             frame_last;
   } rsp_payload_type;

   // control carried with an item from accept to the line buffer stage
   typedef struct packed {
      logic drain;
      logic emit;
      logic border;
      logic sel_a;
      logic last;
   } item_ctrl_type;

   // control carried with a result through the arithmetic stages
   typedef struct packed {
      logic             conv;
      logic             last;
      logic [PIX_W-1:0] pass_pixel;
   } res_ctrl_type;

endpackage

>>> rtl/conv3x3_clamp_filter.sv
// streaming 3x3 convolution with clamp over a square 8-bit raster frame
// a req beat passes the line buffer, product and row sum registers, then the rsp register
// throughput: one beat per clock while rsp_ready stays high; the line buffer ram does one read and one write per pixel
// a frame of s*s pixels gives s*s-s-1 results; s+1 drain beats then flush the tail
// reset clears position counters, stage valids and config registers (size 1024, identity)
// line buffers and window are not cleared: every value they feed is written earlier in the frame
module conv3x3_clamp_filter #(
   parameter int MAX_SIZE       = c3cf_pkg::MAX_SIZE_DEF,
   parameter int COEF_FRAC_BITS = c3cf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  c3cf_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output c3cf_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  c3cf_pkg::csr_index_type           csr_index,
   input  logic [c3cf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import c3cf_pkg::*;

   // position counters index columns and rows 0..MAX_SIZE-1
   localparam int POS_W  = $clog2(MAX_SIZE);
   // signed Q2.frac coefficient, three of them per kernel row
   localparam int CW     = COEF_FRAC_BITS + 2;
   localparam int ROW_W  = TAPS * CW;
   // unsigned pixel times signed coefficient, then sums of three and of nine
   localparam int PROD_W = CW + PIX_W + 1;
   localparam int RSUM_W = PROD_W + 2;
   localparam int SUM_W  = PROD_W + 4;
   localparam int Q_W    = SUM_W - COEF_FRAC_BITS;
   // one ram word holds the pixel two rows up (high) and one row up (low)
   localparam int RAM_W  = 2 * PIX_W;

   localparam int SIZE_RESET = (FRAME_SIZE_RESET > MAX_SIZE) ? MAX_SIZE : FRAME_SIZE_RESET;
   localparam logic [POS_W-1:0] SIZE_M1_RESET  = POS_W'(SIZE_RESET - 1);
   // 1.0 in the centre field of the middle row
   localparam logic [ROW_W-1:0] COEF_MID_RESET = ROW_W'(1) << (CW + COEF_FRAC_BITS);

   // ---------------------------------------------------------------- config
   logic [POS_W-1:0]        size_m1_ff, size_m1_in;    // effective frame size minus one
   logic [ROW_W-1:0]        coef_ff [TAPS];
   logic [ROW_W-1:0]        coef_in [TAPS];
   logic [FRAME_SIZE_W-1:0] csr_size;
   logic                    size_write;

   // ---------------------------------------------------------------- input side
   logic [POS_W-1:0] in_row_ff, in_row_in;
   logic [POS_W-1:0] in_col_ff, in_col_in;
   logic             tail_ff, tail_in;              // tail of a finished frame still owed
   logic             tail_first_ff, tail_first_in;  // next drain gives the pixel two rows up
   logic [POS_W-1:0] tail_col_ff, tail_col_in;      // column of the last row to drain next
   logic             is_pixel;
   logic             last_col;
   logic             last_row;
   logic             at_start;
   logic             req_accept;
   item_ctrl_type    ctrl_in;
   logic [POS_W-1:0] rd_addr;

   // ---------------------------------------------------------------- pipeline
   logic             out_load;
   logic             s3_load;
   logic             s2_load;
   logic             s1_load;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   item_ctrl_type    s1_ctrl_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [POS_W-1:0] s1_col_ff;

   logic             byp_ff, byp_in;
   logic [RAM_W-1:0] byp_data_ff;
   logic [RAM_W-1:0] ram_rd_data;
   logic [RAM_W-1:0] ram_word;
   logic             wr_en;
   logic [RAM_W-1:0] wr_data;
   logic [PIX_W-1:0] lb_a;
   logic [PIX_W-1:0] lb_b;

   // window keeps the two older columns, [m][0] oldest; rows top to bottom
   logic [PIX_W-1:0] win_ff  [TAPS][2];
   logic [PIX_W-1:0] col_new [TAPS];
   logic [PIX_W-1:0] tap     [TAPS][TAPS];

   logic                     s2_valid_ff;
   res_ctrl_type             s2_ctrl_ff;
   res_ctrl_type             res_in;
   logic signed [PROD_W-1:0] prod_ff [TAPS][TAPS];
   logic signed [PROD_W-1:0] prod_in [TAPS][TAPS];

   logic                     s3_valid_ff;
   res_ctrl_type             s3_ctrl_ff;
   logic signed [RSUM_W-1:0] rsum_ff [TAPS];
   logic signed [RSUM_W-1:0] rsum_in [TAPS];

   logic signed [SUM_W-1:0]  sum;
   logic [Q_W-1:0]           quot;
   logic                     rsp_valid_ff;
   rsp_payload_type          rsp_data_ff;
   rsp_payload_type          rsp_in;

   // ---------------------------------------------------------------- handshake
   // each stage loads when it is empty or its item moves on
   assign out_load   = !rsp_valid_ff || rsp_ready;
   assign s3_load    = !s3_valid_ff || out_load;
   assign s2_load    = !s2_valid_ff || s3_load;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign req_ready  = s1_load;
   assign req_accept = req_valid && s1_load;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- config writes
   assign csr_size   = csr_wdata[FRAME_SIZE_W-1:0];
   assign size_write = csr_valid && (csr_index == CSR_FRAME_SIZE);

   always_comb begin
      size_m1_in = size_m1_ff;
      coef_in    = coef_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_SIZE: begin
               // saturate to the supported range
               if (csr_size < FRAME_SIZE_W'(FRAME_SIZE_MIN)) begin
                  size_m1_in = POS_W'(FRAME_SIZE_MIN - 1);
               end else if (32'(csr_size) > 32'(MAX_SIZE)) begin
                  size_m1_in = POS_W'(MAX_SIZE - 1);
               end else begin
                  size_m1_in = POS_W'(csr_size - FRAME_SIZE_W'(1));
               end
            end
            CSR_COEF_TOP: coef_in[0] = ROW_W'(csr_wdata);
            CSR_COEF_MID: coef_in[1] = ROW_W'(csr_wdata);
            CSR_COEF_BOT: coef_in[2] = ROW_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- accept stage
   // a pixel at (row, col) completes the window centred on raster index minus s+1;
   // that output sits at (row-1, col-1), or at (row-2, s-1) when col is 0
   assign is_pixel = (req_data.kind == KIND_PIXEL);
   assign last_col = (in_col_ff == size_m1_ff);
   assign last_row = (in_row_ff == size_m1_ff);
   assign at_start = (in_row_ff == '0) && (in_col_ff == '0);

   always_comb begin
      ctrl_in = '0;
      rd_addr = in_col_ff;
      if (is_pixel) begin
         // nothing comes out for the first s+1 pixels of a frame
         ctrl_in.emit   = (in_row_ff > POS_W'(1)) ||
                          ((in_row_ff == POS_W'(1)) && (in_col_ff != '0));
         // output in the top row or in the first or last column
         ctrl_in.border = (in_col_ff == '0) || (in_col_ff == POS_W'(1)) ||
                          (in_row_ff == POS_W'(1));
      end else begin
         // drain: the pixel two rows up in the last column, then the whole last row
         ctrl_in.drain = 1'b1;
         ctrl_in.emit  = tail_ff;
         ctrl_in.sel_a = tail_first_ff;
         ctrl_in.last  = !tail_first_ff && (tail_col_ff == size_m1_ff);
         rd_addr       = tail_first_ff ? size_m1_ff : tail_col_ff;
      end
   end

   // drains that owe nothing are dropped here
   assign s1_valid_in = req_accept && (is_pixel || tail_ff);

   always_comb begin
      in_row_in     = in_row_ff;
      in_col_in     = in_col_ff;
      tail_in       = tail_ff;
      tail_first_in = tail_first_ff;
      tail_col_in   = tail_col_ff;
      if (req_accept) begin
         if (is_pixel) begin
            in_col_in = last_col ? '0 : in_col_ff + POS_W'(1);
            if (last_col) begin
               in_row_in = last_row ? '0 : in_row_ff + POS_W'(1);
            end
            // a new frame drops any tail still owed
            if (at_start) begin
               tail_in = 1'b0;
            end
            if (last_col && last_row) begin
               tail_in       = 1'b1;
               tail_first_in = 1'b1;
               tail_col_in   = '0;
            end
         end else if (tail_ff) begin
            if (tail_first_ff) begin
               tail_first_in = 1'b0;
            end else begin
               tail_col_in = tail_col_ff + POS_W'(1);
               if (ctrl_in.last) begin
                  tail_in = 1'b0;
               end
            end
         end
      end
      // a size change restarts the frame
      if (size_write) begin
         in_row_in = '0;
         in_col_in = '0;
         tail_in   = 1'b0;
      end
   end

   // ---------------------------------------------------------------- line buffer stage
   // the ram read issued with the accept returns here; the column is written back
   // shifted one row up when the item leaves, in the same edge the next item reads
   c3cf_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_SIZE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (s1_load),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // the ram reads old data on a same address write, so forward the new word
   assign ram_word = byp_ff ? byp_data_ff : ram_rd_data;
   assign lb_a     = ram_word[RAM_W-1:PIX_W];
   assign lb_b     = ram_word[PIX_W-1:0];
   assign wr_en    = s1_valid_ff && s2_load && !s1_ctrl_ff.drain;
   assign wr_data  = {lb_b, s1_pixel_ff};
   assign byp_in   = wr_en && (s1_col_ff == rd_addr);

   assign col_new[0] = lb_a;
   assign col_new[1] = lb_b;
   assign col_new[2] = s1_pixel_ff;

   // window after the shift, products against the kernel (left field in high bits)
   always_comb begin
      for (int m = 0; m < TAPS; m++) begin
         tap[m][0] = win_ff[m][0];
         tap[m][1] = win_ff[m][1];
         tap[m][2] = col_new[m];
         for (int n = 0; n < TAPS; n++) begin
            prod_in[m][n] = $signed({1'b0, tap[m][n]}) *
                            $signed(coef_ff[m][(TAPS-1-n)*CW +: CW]);
         end
      end
   end

   always_comb begin
      res_in.conv = !s1_ctrl_ff.drain && !s1_ctrl_ff.border;
      res_in.last = s1_ctrl_ff.last;
      if (s1_ctrl_ff.drain) begin
         res_in.pass_pixel = s1_ctrl_ff.sel_a ? lb_a : lb_b;
      end else begin
         // centre of the shifted window is the newer stored column, middle row
         res_in.pass_pixel = win_ff[1][1];
      end
   end

   // ---------------------------------------------------------------- row sums
   always_comb begin
      for (int m = 0; m < TAPS; m++) begin
         rsum_in[m] = RSUM_W'(prod_ff[m][0]) + RSUM_W'(prod_ff[m][1]) +
                      RSUM_W'(prod_ff[m][2]);
      end
   end

   // ---------------------------------------------------------------- final sum and clamp
   assign sum  = SUM_W'(rsum_ff[0]) + SUM_W'(rsum_ff[1]) + SUM_W'(rsum_ff[2]);
   assign quot = sum[SUM_W-1:COEF_FRAC_BITS];

   always_comb begin
      rsp_in.frame_last = s3_ctrl_ff.last;
      if (!s3_ctrl_ff.conv) begin
         rsp_in.out_pixel = s3_ctrl_ff.pass_pixel;
      end else if (sum[SUM_W-1]) begin
         rsp_in.out_pixel = '0;
      end else if (|quot[Q_W-1:PIX_W]) begin
         rsp_in.out_pixel = PIX_W'(PIX_MAX);
      end else begin
         rsp_in.out_pixel = quot[PIX_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_m1_ff    <= SIZE_M1_RESET;
         coef_ff[0]    <= '0;
         coef_ff[1]    <= COEF_MID_RESET;
         coef_ff[2]    <= '0;
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         tail_ff       <= 1'b0;
         tail_first_ff <= 1'b0;
         tail_col_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         byp_ff        <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         size_m1_ff    <= size_m1_in;
         coef_ff       <= coef_in;
         in_row_ff     <= in_row_in;
         in_col_ff     <= in_col_in;
         tail_ff       <= tail_in;
         tail_first_ff <= tail_first_in;
         tail_col_ff   <= tail_col_in;
         if (s1_load) begin
            s1_valid_ff <= s1_valid_in;
            byp_ff      <= byp_in;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff && s1_ctrl_ff.emit;
         end
         if (s3_load) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_load) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ctrl_ff  <= ctrl_in;
         s1_pixel_ff <= req_data.pixel;
         s1_col_ff   <= in_col_ff;
         byp_data_ff <= wr_data;
      end
      if (wr_en) begin
         for (int m = 0; m < TAPS; m++) begin
            win_ff[m][0] <= win_ff[m][1];
            win_ff[m][1] <= col_new[m];
         end
      end
      if (s2_load) begin
         s2_ctrl_ff <= res_in;
         prod_ff    <= prod_in;
      end
      if (s3_load) begin
         s3_ctrl_ff <= s2_ctrl_ff;
         rsum_ff    <= rsum_in;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

>>> rtl/c3cf_ram.sv
// generic simple dual port ram with registered read, read-first
module c3cf_ram #(
   parameter int WIDTH = 2 * c3cf_pkg::PIX_W,
   parameter int DEPTH = c3cf_pkg::MAX_SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/c3cf_checker.sv
// port level checks of the 3x3 clamp filter and their bind
module c3cf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input c3cf_pkg::rsp_payload_type rsp_data
);

   import c3cf_pkg::*;

   // a waiting result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   // with the result side open nothing may hold off the input
   a_ready_open: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low while the result side is free");

   // a result appearing after an idle output comes from a req beat that passed every stage without a stall
   a_latency: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 rsp_valid
      |-> $past(req_valid && req_ready, RSP_LATENCY))
      else $error("rsp beat without a req beat at the pipeline latency");

   // reset empties the pipeline and opens the input
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

bind conv3x3_clamp_filter c3cf_checker u_c3cf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/sv/conv3x3_clamp_filter_test.sv
// testbench for conv3x3_clamp_filter: directed table, then random frames against a predictor
module conv3x3_clamp_filter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import c3cf_pkg::*;

   localparam int  MAX_PIX      = MAX_SIZE_DEF;
   localparam int  FRAC         = COEF_FRAC_BITS_DEF;
   localparam int  CW           = FRAC + 2;
   localparam int  STALL_LIMIT  = 2000;
   localparam int  RANDOM_ITEMS = 400;
   localparam real PERIOD       = 12.0;
   localparam logic KIND_DRAIN  = ~KIND_PIXEL;

   // directed table row kinds
   typedef enum logic [1:0] {
      ROW_PIXEL,
      ROW_DRAIN,
      ROW_CSR
   } row_op_type;

   typedef struct packed {
      row_op_type          op;
      logic [PIX_W-1:0]    pixel;
      csr_index_type       idx;
      logic [CSR_DATA_W-1:0] data;
      bit                  typed;
      rsp_payload_type     want;
   } stim_row_type;

   // dut ports; the inputs are known from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_FRAME_SIZE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state: two rows above the input, 3x3 neighbourhood, positions
   logic [PIX_W-1:0]      row_above2 [0:MAX_PIX-1];
   logic [PIX_W-1:0]      row_above1 [0:MAX_PIX-1];
   logic [PIX_W-1:0]      win_px [0:2][0:2];
   int unsigned           pos_row;
   int unsigned           pos_col;
   int unsigned           out_idx;
   logic [FRAME_SIZE_W-1:0] cfg_size;
   logic [CSR_DATA_W-1:0] cfg_coef [0:2];

   // filtered pixels still owed by the block, oldest first
   rsp_payload_type       pending_pixels [$];

   int unsigned           sender_gap_pct     = 8;
   int unsigned           receiver_stall_pct = 67;
   int                    error_count        = 0;
   int                    results_checked    = 0;
   int                    frames_sent        = 0;
   int                    csr_writes         = 0;
   int                    random_items       = 0;
   int                    stall_cycles       = 0;

   always #(PERIOD / 2) clock = ~clock;

   conv3x3_clamp_filter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------- predictor

   // frame size register saturated to the supported range
   function automatic int unsigned active_size();
      int unsigned s;
      s = cfg_size;
      if (s < FRAME_SIZE_MIN) s = FRAME_SIZE_MIN;
      if (s > MAX_PIX) s = MAX_PIX;
      return s;
   endfunction

   // nine signed q2.10 taps over the window, negative to zero, floor, clamp at 255
   function automatic logic [PIX_W-1:0] kernel_sum();
      longint        acc;
      longint        tap;
      longint        q;
      logic [CW-1:0] c;
      int            m;
      int            n;
      acc = 0;
      for (m = 0; m < TAPS; m++) begin
         for (n = 0; n < TAPS; n++) begin
            c   = cfg_coef[m][(2 - n) * CW +: CW];
            tap = $signed(c);
            acc += longint'(win_px[m][n]) * tap;
         end
      end
      if (acc < 0) return '0;
      q = acc >>> FRAC;
      if (q > PIX_MAX) return PIX_MAX[PIX_W-1:0];
      return q[PIX_W-1:0];
   endfunction

   function automatic void csr_apply(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_FRAME_SIZE: begin
            // a size write restarts the frame
            cfg_size = data[FRAME_SIZE_W-1:0];
            pos_row  = 0;
            pos_col  = 0;
            out_idx  = 0;
         end
         CSR_COEF_TOP: cfg_coef[0] = data;
         CSR_COEF_MID: cfg_coef[1] = data;
         CSR_COEF_BOT: cfg_coef[2] = data;
         default: ;
      endcase
   endfunction

   // one req beat into the predictor; has tells whether it causes an rsp beat
   function automatic void filter_step(input logic kind, input logic [PIX_W-1:0] px,
                                       output bit has, output rsp_payload_type res);
      int unsigned      s;
      int unsigned      total;
      int unsigned      idx;
      int unsigned      o;
      int unsigned      orow;
      int unsigned      ocol;
      int unsigned      raster;
      int               r;
      logic [PIX_W-1:0] val;
      bit               at_start;
      s        = active_size();
      total    = s * s;
      at_start = (pos_row == 0 && pos_col == 0);
      has      = 1'b0;
      res      = '0;
      if (kind == KIND_DRAIN) begin
         // drain only counts with the frame complete and its tail owed
         if (!at_start || out_idx == 0) return;
         o = out_idx;
         if (o <= total - s - 1) val = row_above2[s - 1];
         else val = row_above1[o - (total - s)];
      end else begin
         // a pixel at frame start drops whatever tail was still owed
         if (at_start) out_idx = 0;
         idx = pos_col;
         if (idx >= s) idx = s - 1;
         for (r = 0; r < TAPS; r++) begin
            win_px[r][0] = win_px[r][1];
            win_px[r][1] = win_px[r][2];
         end
         win_px[0][2]    = row_above2[idx];
         win_px[1][2]    = row_above1[idx];
         win_px[2][2]    = px;
         row_above2[idx] = row_above1[idx];
         row_above1[idx] = px;
         raster = pos_row * s + pos_col;
         pos_col++;
         if (pos_col >= s) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= s) pos_row = 0;
         end
         // output lags the input by one row plus one pixel
         if (raster < s + 1) return;
         o    = out_idx;
         orow = o / s;
         ocol = o % s;
         if (orow == 0 || ocol == 0 || orow >= s - 1 || ocol >= s - 1) val = win_px[1][1];
         else val = kernel_sum();
      end
      out_idx        = (o >= total - 1) ? 0 : o + 1;
      has            = 1'b1;
      res.out_pixel  = val;
      res.frame_last = (o >= total - 1);
   endfunction

   // ---------------------------------------------------------------- drivers

   // receiver side stalls at random, driven at the rising edge
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // lower both senders, wait for every owed beat, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   // one register write beat; valid stays up for a following write
   task automatic csr_beat(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      csr_apply(idx, data);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_writes++;
   endtask

   task automatic write_settings(input logic [FRAME_SIZE_W-1:0] size,
                                 input logic [CSR_DATA_W-1:0] top,
                                 input logic [CSR_DATA_W-1:0] mid,
                                 input logic [CSR_DATA_W-1:0] bot);
      wait_idle();
      csr_beat(CSR_FRAME_SIZE, {{(CSR_DATA_W - FRAME_SIZE_W){1'b0}}, size});
      csr_beat(CSR_COEF_TOP, top);
      csr_beat(CSR_COEF_MID, mid);
      csr_beat(CSR_COEF_BOT, bot);
   endtask

   // one req beat; a typed expectation replaces the predicted one
   task automatic push_req(input logic kind, input logic [PIX_W-1:0] pixel,
                           input bit typed, input rsp_payload_type want);
      bit              has;
      rsp_payload_type got;
      req_payload_type beat;
      beat.kind  = kind;
      beat.pixel = pixel;
      if ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_gap_pct);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      csr_valid <= 1'b0;
      filter_step(kind, pixel, has, got);
      if (typed) pending_pixels.push_back(want);
      else if (has) pending_pixels.push_back(got);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // mostly whole frames with their tail drains; some noise and broken frames
   task automatic run_frame(input bit last_in_phase, input bit big);
      int unsigned s;
      int unsigned total;
      int unsigned k;
      int unsigned noise_at;
      int unsigned tail;
      int unsigned i;
      int unsigned r;
      s     = active_size();
      total = s * s;
      frames_sent++;
      if (big) begin
         // largest size: a few pixels with no output yet, the next size write restarts
         for (i = 0; i < 25; i++) push_req(KIND_PIXEL, 8'($urandom_range(255)), 1'b0, '0);
         random_items += 25;
         return;
      end
      r = $urandom_range(99);
      if (last_in_phase && r < 25) begin
         // cut off mid-frame; the next size write restarts the block
         k = $urandom_range(total - 1, 1);
         for (i = 0; i < k; i++) push_req(KIND_PIXEL, 8'($urandom_range(255)), 1'b0, '0);
         random_items += k;
         return;
      end
      noise_at = ($urandom_range(99) < 15) ? $urandom_range(total - 1, 1) : 0;
      for (i = 0; i < total; i++) begin
         // stray drain inside the frame, ignored by the block
         if (noise_at != 0 && i == noise_at)
            push_req(KIND_DRAIN, 8'($urandom_range(255)), 1'b0, '0);
         push_req(KIND_PIXEL, 8'($urandom_range(255)), 1'b0, '0);
      end
      // full tail flush, or a short one that the next frame discards
      tail = (r < 80) ? s + 1 : $urandom_range(s, 0);
      for (i = 0; i < tail; i++) push_req(KIND_DRAIN, 8'($urandom_range(255)), 1'b0, '0);
      // drain with nothing owed
      if (r < 8) push_req(KIND_DRAIN, 8'($urandom_range(255)), 1'b0, '0);
      random_items += total + tail;
   endtask

   function automatic logic [CSR_DATA_W-1:0] gentle_row();
      logic [CSR_DATA_W-1:0] v;
      int                    n;
      for (n = 0; n < TAPS; n++) v[n * CW +: CW] = CW'($urandom_range(500) - 200);
      return v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] wild_row();
      return {4'($urandom_range(15)), $urandom};
   endfunction

   function automatic stim_row_type mk(input row_op_type op, input logic [PIX_W-1:0] pixel,
                                       input bit typed, input logic [PIX_W-1:0] want_px,
                                       input logic want_last);
      stim_row_type t;
      t                 = '0;
      t.op              = op;
      t.pixel           = pixel;
      t.typed           = typed;
      t.want.out_pixel  = want_px;
      t.want.frame_last = want_last;
      return t;
   endfunction

   function automatic stim_row_type mk_csr(input csr_index_type idx,
                                           input logic [CSR_DATA_W-1:0] data);
      stim_row_type t;
      t      = '0;
      t.op   = ROW_CSR;
      t.idx  = idx;
      t.data = data;
      return t;
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: rsp beat with nothing owed: expected none, got pixel %h last %b",
                     $time, rsp_data.out_pixel, rsp_data.frame_last);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            results_checked++;
            if (rsp_data.out_pixel !== want.out_pixel) begin
               $display("%0t: out_pixel mismatch: expected %h, got %h",
                        $time, want.out_pixel, rsp_data.out_pixel);
               error_count++;
            end
            if (rsp_data.frame_last !== want.frame_last) begin
               $display("%0t: frame_last mismatch: expected %b, got %b",
                        $time, want.frame_last, rsp_data.frame_last);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles in which no channel moves a beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d results still owed",
                  $time, stall_cycles, pending_pixels.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      stim_row_type          directed [$];
      stim_row_type          row;
      logic [FRAME_SIZE_W-1:0] size;
      logic [CSR_DATA_W-1:0] top;
      logic [CSR_DATA_W-1:0] mid;
      logic [CSR_DATA_W-1:0] bot;
      bit                    big;
      int                    i;
      int                    f;
      int                    frames;
      int                    phase;
      int unsigned           pick;

      // predictor reset state: size 1024, identity kernel
      for (i = 0; i < MAX_PIX; i++) begin
         row_above2[i] = '0;
         row_above1[i] = '0;
      end
      for (i = 0; i < TAPS * TAPS; i++) win_px[i / TAPS][i % TAPS] = '0;
      pos_row     = 0;
      pos_col     = 0;
      out_idx     = 0;
      cfg_size    = FRAME_SIZE_RESET;
      cfg_coef[0] = '0;
      cfg_coef[1] = 36'd1 << (CW + FRAC);
      cfg_coef[2] = '0;

      // reset kernel is identity, so the first 3x3 frame comes back unchanged;
      // then all taps at the largest positive value saturate the centre
      directed = '{
         mk_csr(CSR_FRAME_SIZE, 36'd0),               // saturates up to 3
         mk(ROW_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0),
         mk(ROW_PIXEL, 8'hff, 1'b0, 8'h00, 1'b0),
         mk(ROW_DRAIN, 8'h00, 1'b0, 8'h00, 1'b0),     // mid-frame drain, ignored
         mk(ROW_PIXEL, 8'h01, 1'b0, 8'h00, 1'b0),
         mk(ROW_PIXEL, 8'h80, 1'b0, 8'h00, 1'b0),
         mk(ROW_PIXEL, 8'h7f, 1'b1, 8'h00, 1'b0),
         mk(ROW_PIXEL, 8'haa, 1'b1, 8'hff, 1'b0),
         mk(ROW_PIXEL, 8'h55, 1'b1, 8'h01, 1'b0),
         mk(ROW_PIXEL, 8'hfe, 1'b1, 8'h80, 1'b0),
         mk(ROW_PIXEL, 8'h10, 1'b1, 8'h7f, 1'b0),     // centre through identity
         mk(ROW_DRAIN, 8'h00, 1'b1, 8'haa, 1'b0),
         mk(ROW_DRAIN, 8'hff, 1'b1, 8'h55, 1'b0),
         mk(ROW_DRAIN, 8'h00, 1'b1, 8'hfe, 1'b0),
         mk(ROW_DRAIN, 8'h00, 1'b1, 8'h10, 1'b1),
         mk(ROW_DRAIN, 8'h00, 1'b0, 8'h00, 1'b0),     // nothing owed, ignored
         mk_csr(CSR_COEF_TOP, 36'h7ff7ff7ff),
         mk_csr(CSR_COEF_MID, 36'h7ff7ff7ff),
         mk_csr(CSR_COEF_BOT, 36'h7ff7ff7ff),
         mk(ROW_PIXEL, 8'h01, 1'b0, 8'h00, 1'b0),
         mk(ROW_PIXEL, 8'h02, 1'b0, 8'h00, 1'b0),
         mk(ROW_PIXEL, 8'h03, 1'b0, 8'h00, 1'b0),
         mk(ROW_PIXEL, 8'h04, 1'b0, 8'h00, 1'b0),
         mk(ROW_PIXEL, 8'h05, 1'b1, 8'h01, 1'b0),
         mk(ROW_PIXEL, 8'h06, 1'b1, 8'h02, 1'b0),
         mk(ROW_PIXEL, 8'h07, 1'b1, 8'h03, 1'b0),
         mk(ROW_PIXEL, 8'hff, 1'b1, 8'h04, 1'b0),
         mk(ROW_PIXEL, 8'hff, 1'b1, 8'hff, 1'b0),     // saturated centre
         mk(ROW_DRAIN, 8'h00, 1'b1, 8'h06, 1'b0),
         mk(ROW_DRAIN, 8'h00, 1'b1, 8'h07, 1'b0),
         mk(ROW_PIXEL, 8'hc3, 1'b0, 8'h00, 1'b0)      // new frame drops the owed tail
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed.size(); i++) begin
         row = directed[i];
         if (row.op == ROW_CSR) begin
            if (i == 0 || directed[i - 1].op != ROW_CSR) wait_idle();
            csr_beat(row.idx, row.data);
         end else begin
            push_req((row.op == ROW_DRAIN) ? KIND_DRAIN : KIND_PIXEL, row.pixel,
                     row.typed, row.want);
         end
      end

      // random phases, each with its own settings
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         // idle pattern: sender light then heavy, then no idling at all
         if (random_items < RANDOM_ITEMS / 3) begin
            sender_gap_pct     = 8;
            receiver_stall_pct = 67;
         end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
            sender_gap_pct     = 67;
            receiver_stall_pct = 8;
         end else begin
            sender_gap_pct     = 0;
            receiver_stall_pct = 0;
         end
         big  = 1'b0;
         pick = $urandom_range(99);
         size = FRAME_SIZE_W'($urandom_range(7, 3));
         top  = gentle_row();
         mid  = gentle_row();
         bot  = gentle_row();
         case (phase)
            0: begin
               // most negative taps everywhere
               size = FRAME_SIZE_W'(3);
               top  = 36'h800800800;
               mid  = 36'h800800800;
               bot  = 36'h800800800;
            end
            1: begin
               // top of the size field, saturates to the largest frame
               size = '1;
               big  = 1'b1;
            end
            2: begin
               top = '1;
               mid = '1;
               bot = '1;
            end
            3: begin
               size = FRAME_SIZE_W'(1);
               top  = '0;
               mid  = '0;
               bot  = '0;
            end
            default: begin
               if (pick < 10) size = FRAME_SIZE_W'($urandom_range(16, 8));
               if (pick >= 40 && pick < 75) begin
                  top = wild_row();
                  mid = wild_row();
                  bot = wild_row();
               end else if (pick >= 75) begin
                  mid[CW +: CW] = CW'(1 << FRAC);
               end
            end
         endcase
         write_settings(size, top, mid, bot);
         frames = big ? 1 : $urandom_range(3, 1);
         for (f = 0; f < frames && random_items < RANDOM_ITEMS; f++) begin
            run_frame(f == frames - 1, big);
            // now and then hold off until every owed beat is back
            if ($urandom_range(99) < 15) wait_idle();
         end
         phase++;
      end

      wait_idle();
      repeat (4 * RSP_LATENCY) @(posedge clock);

      $display("covered %0d frames over %0d settings with %0d register writes",
               frames_sent, phase + 2, csr_writes);
      $display("checked %0d rsp beats, %0d errors", results_checked, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
